// ===== rtl/core/dip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_pkg: shared types, constants and helpers for the integer power core
// Binary64 field widths, state encodings, controller/datapath bundles and
// the common round-and-pack function used by the multiplier and reciprocal.
// ----------------------------------------------------------------------------
package dip_pkg;

   localparam int unsigned FP_W    = 64;
   localparam int unsigned EXP_W   = 32;
   localparam int unsigned LIM_W   = 16;
   localparam int unsigned SIG_W   = 53;
   localparam int unsigned PROD_W  = 106;
   localparam int unsigned QUO_W   = 56;
   localparam int unsigned EBIAS_W = 13;

   localparam logic [FP_W-1:0] FP_ONE     = 64'h3FF0_0000_0000_0000;
   localparam logic [FP_W-1:0] FP_QNAN    = 64'h7FF8_0000_0000_0000;
   localparam logic [10:0]     EXP_ALL1   = 11'h7FF;
   localparam logic [LIM_W-1:0] LIM_RESET = 16'd100;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_CHECK,
      CS_RECIP,
      CS_LOOP,
      CS_MUL,
      CS_SQR,
      CS_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      FM_IDLE,
      FM_MUL,
      FM_NORM,
      FM_ROUND
   } fmul_state_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_NORM,
      FR_DIV,
      FR_ROUND
   } frcp_state_type;

   typedef struct packed {
      logic load;
      logic clr_res;
      logic recip_go;
      logic mul_go;
      logic mul_sq;
      logic wr_x_recip;
      logic wr_res;
      logic wr_x_sq;
   } dp_cmd_type;

   typedef struct packed {
      logic pass;
      logic neg;
      logic m_zero;
      logic m_one;
      logic m_lsb;
      logic mul_done;
      logic recip_done;
   } dp_status_type;

   // exact binary64 encoding of an unsigned 16-bit integer
   function automatic logic [FP_W-1:0] lim_to_bits(input logic [LIM_W-1:0] lim);
      logic [3:0]  msb;
      logic [67:0] w;
      logic [10:0] ef;
      msb = 4'd0;
      for (int i = 0; i < LIM_W; i++) begin
         if (lim[i]) begin
            msb = 4'(i);
         end
      end
      w  = {52'd0, lim} << (7'd52 - {3'd0, msb});
      ef = 11'd1023 + {7'd0, msb};
      if (lim == '0) begin
         lim_to_bits = '0;
      end else begin
         lim_to_bits = {1'b0, ef, w[51:0]};
      end
   endfunction

   // p holds the significand with its leading one at bit 105 (or e == 1 for
   // a denormal); e is the biased exponent. Rounds to nearest even and packs.
   function automatic logic [FP_W-1:0] round_pack(input logic sgn,
                                                 input logic signed [EBIAS_W-1:0] e,
                                                 input logic [PROD_W-1:0] p,
                                                 input logic st);
      logic signed [EBIAS_W-1:0] amt;
      logic signed [EBIAS_W-1:0] e2;
      logic [PROD_W-1:0] sh;
      logic [PROD_W-1:0] msk;
      logic sticky;
      logic [SIG_W:0] m;
      logic g;
      sh     = p;
      sticky = st;
      e2     = e;
      amt    = '0;
      msk    = '0;
      if (e < 13'sd1) begin
         amt = 13'sd1 - e;
         e2  = 13'sd1;
         if (amt > 13'sd106) begin
            sh     = '0;
            sticky = st | (|p);
         end else begin
            msk    = ({{(PROD_W-1){1'b0}}, 1'b1} << amt[6:0]) - 106'd1;
            sh     = p >> amt[6:0];
            sticky = st | (|(p & msk));
         end
      end
      m      = {1'b0, sh[105:53]};
      g      = sh[52];
      sticky = sticky | (|sh[51:0]);
      if (g && (sticky || m[0])) begin
         m = m + 54'd1;
      end
      if (m[SIG_W]) begin
         m  = m >> 1;
         e2 = e2 + 13'sd1;
      end
      if (e2 >= 13'sd2047) begin
         round_pack = {sgn, EXP_ALL1, 52'd0};
      end else if (m[52]) begin
         round_pack = {sgn, e2[10:0], m[51:0]};
      end else begin
         round_pack = {sgn, 11'd0, m[51:0]};
      end
   endfunction

endpackage

// ===== rtl/core/dip_fmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_fmul: multi-cycle binary64 multiplier
// Four 27x27 partial products accumulated over cycles, bit-serial
// normalization for denormal operands, then round to nearest even.
// ----------------------------------------------------------------------------
module dip_fmul
   import dip_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [FP_W-1:0] op_a,
   input  logic [FP_W-1:0] op_b,
   output logic            done,
   output logic [FP_W-1:0] result
);

   fmul_state_type state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [SIG_W-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic signed [EBIAS_W-1:0] e_ff, e_in;
   logic sgn_ff, sgn_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [53:0] pp_ff, pp_in;
   logic [1:0]  sh_ff, sh_in;
   logic [FP_W-1:0] res_ff, res_in;
   logic done_ff, done_in;

   logic [10:0] ea, eb;
   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [26:0] opx, opy;
   logic [PROD_W-1:0] pp_ext;

   assign ea     = op_a[62:52];
   assign eb     = op_b[62:52];
   assign a_nan  = (ea == EXP_ALL1) && (op_a[51:0] != '0);
   assign b_nan  = (eb == EXP_ALL1) && (op_b[51:0] != '0);
   assign a_inf  = (ea == EXP_ALL1) && (op_a[51:0] == '0);
   assign b_inf  = (eb == EXP_ALL1) && (op_b[51:0] == '0);
   assign a_zero = (op_a[62:0] == '0);
   assign b_zero = (op_b[62:0] == '0);

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin opx = ma_ff[26:0];         opy = mb_ff[26:0];         end
         2'd1: begin opx = ma_ff[26:0];         opy = {1'b0, mb_ff[52:27]}; end
         2'd2: begin opx = {1'b0, ma_ff[52:27]}; opy = mb_ff[26:0];         end
         default: begin opx = {1'b0, ma_ff[52:27]}; opy = {1'b0, mb_ff[52:27]}; end
      endcase
   end

   always_comb begin
      case (sh_ff)
         2'd0:    pp_ext = {52'd0, pp_ff};
         2'd1:    pp_ext = {52'd0, pp_ff} << 27;
         default: pp_ext = {52'd0, pp_ff} << 54;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      e_in     = e_ff;
      sgn_in   = sgn_ff;
      acc_in   = acc_ff;
      pp_in    = pp_ff;
      sh_in    = sh_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         FM_IDLE: begin
            if (go) begin
               sgn_in = op_a[63] ^ op_b[63];
               ma_in  = {ea != '0, op_a[51:0]};
               mb_in  = {eb != '0, op_b[51:0]};
               e_in   = EBIAS_W'({2'd0, (ea == '0) ? 11'd1 : ea})
                      + EBIAS_W'({2'd0, (eb == '0) ? 11'd1 : eb}) - 13'sd1022;
               acc_in = '0;
               cnt_in = '0;
               if (a_nan) begin
                  res_in = op_a | 64'h0008_0000_0000_0000;
                  done_in = 1'b1;
               end else if (b_nan) begin
                  res_in = op_b | 64'h0008_0000_0000_0000;
                  done_in = 1'b1;
               end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                  res_in = FP_QNAN;
                  done_in = 1'b1;
               end else if (a_inf || b_inf) begin
                  res_in = {op_a[63] ^ op_b[63], EXP_ALL1, 52'd0};
                  done_in = 1'b1;
               end else if (a_zero || b_zero) begin
                  res_in = {op_a[63] ^ op_b[63], 63'd0};
                  done_in = 1'b1;
               end else begin
                  state_in = FM_MUL;
               end
            end
         end
         FM_MUL: begin
            // register one partial product, add the previous one
            pp_in  = opx * opy;
            sh_in  = (cnt_ff == 3'd0) ? 2'd0 : (cnt_ff == 3'd3) ? 2'd2 : 2'd1;
            if (cnt_ff != 3'd0) begin
               acc_in = acc_ff + pp_ext;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = FM_NORM;
            end
         end
         FM_NORM: begin
            if (!acc_ff[PROD_W-1] && (e_ff > 13'sd1)) begin
               acc_in = acc_ff << 1;
               e_in   = e_ff - 13'sd1;
            end else begin
               state_in = FM_ROUND;
            end
         end
         FM_ROUND: begin
            res_in   = round_pack(sgn_ff, e_ff, acc_ff, 1'b0);
            done_in  = 1'b1;
            state_in = FM_IDLE;
         end
         default: state_in = FM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      e_ff   <= e_in;
      sgn_ff <= sgn_in;
      acc_ff <= acc_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/core/dip_frcp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_frcp: multi-cycle binary64 reciprocal
// Normalizes the significand one bit a cycle, then restoring division of
// one by the significand, one quotient bit a cycle, then rounds.
// ----------------------------------------------------------------------------
module dip_frcp
   import dip_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [FP_W-1:0] op_a,
   output logic            done,
   output logic [FP_W-1:0] result
);

   frcp_state_type state_ff, state_in;
   logic [SIG_W-1:0] d_ff, d_in;
   logic signed [EBIAS_W-1:0] e_ff, e_in;
   logic sgn_ff, sgn_in;
   logic [54:0] rem_ff, rem_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [FP_W-1:0] res_ff, res_in;
   logic done_ff, done_in;

   logic [10:0] ea;
   logic [54:0] diff;
   logic [PROD_W-1:0] p_al;
   logic signed [EBIAS_W-1:0] e_al;

   assign ea   = op_a[62:52];
   assign diff = rem_ff - {2'd0, d_ff};

   always_comb begin
      p_al = {q_ff, 50'd0};
      e_al = 13'sd2046 - e_ff;
      if (!p_al[PROD_W-1]) begin
         p_al = p_al << 1;
         e_al = e_al - 13'sd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      sgn_in   = sgn_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (go) begin
               sgn_in = op_a[63];
               d_in   = {ea != '0, op_a[51:0]};
               e_in   = EBIAS_W'({2'd0, (ea == '0) ? 11'd1 : ea});
               rem_in = 55'd1 << 52;
               q_in   = '0;
               cnt_in = '0;
               if ((ea == EXP_ALL1) && (op_a[51:0] != '0)) begin
                  res_in  = op_a | 64'h0008_0000_0000_0000;
                  done_in = 1'b1;
               end else if (ea == EXP_ALL1) begin
                  res_in  = {op_a[63], 63'd0};
                  done_in = 1'b1;
               end else if (op_a[62:0] == '0) begin
                  res_in  = {op_a[63], EXP_ALL1, 52'd0};
                  done_in = 1'b1;
               end else begin
                  state_in = FR_NORM;
               end
            end
         end
         FR_NORM: begin
            if (!d_ff[SIG_W-1]) begin
               d_in = d_ff << 1;
               e_in = e_ff - 13'sd1;
            end else begin
               state_in = FR_DIV;
            end
         end
         FR_DIV: begin
            if (!diff[54]) begin
               rem_in = diff << 1;
               q_in   = {q_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_ff << 1;
               q_in   = {q_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(QUO_W - 1)) begin
               state_in = FR_ROUND;
            end
         end
         FR_ROUND: begin
            res_in   = round_pack(sgn_ff, e_al, p_al, rem_ff != '0);
            done_in  = 1'b1;
            state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      d_ff   <= d_in;
      e_ff   <= e_in;
      sgn_ff <= sgn_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/core/dip_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_datapath: operand registers, limit register and arithmetic units
// Holds base, running result and exponent magnitude; drives the shared
// multiplier and the reciprocal unit under controller commands.
// ----------------------------------------------------------------------------
module dip_datapath
   import dip_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic [FP_W-1:0]         base_bits,
   input  logic signed [EXP_W-1:0] exponent,
   input  logic                    lim_we,
   input  logic [LIM_W-1:0]        lim_data,
   output logic [FP_W-1:0]         power_bits
);

   logic [LIM_W-1:0] lim_ff;
   logic [FP_W-1:0]  x_ff, res_ff;
   logic [EXP_W-1:0] m_ff;
   logic neg_ff, pass_ff;

   logic [FP_W-1:0] mul_a, mul_res, rcp_res;
   logic mul_done, rcp_done;

   assign mul_a = cmd.mul_sq ? x_ff : res_ff;

   dip_fmul u_fmul (
      .clock  (clock),
      .reset  (reset),
      .go     (cmd.mul_go),
      .op_a   (mul_a),
      .op_b   (x_ff),
      .done   (mul_done),
      .result (mul_res)
   );

   dip_frcp u_frcp (
      .clock  (clock),
      .reset  (reset),
      .go     (cmd.recip_go),
      .op_a   (x_ff),
      .done   (rcp_done),
      .result (rcp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIM_RESET;
      end else if (lim_we) begin
         lim_ff <= lim_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= base_bits;
         res_ff  <= FP_ONE;
         neg_ff  <= exponent[EXP_W-1];
         m_ff    <= exponent[EXP_W-1] ? (~exponent + 32'd1) : exponent;
         // positive doubles order like their bit patterns; NaN sits above inf
         pass_ff <= {1'b0, base_bits[62:0]} < lim_to_bits(lim_ff);
      end else begin
         if (cmd.clr_res) begin
            res_ff <= '0;
         end else if (cmd.wr_res) begin
            res_ff <= mul_res;
         end
         if (cmd.wr_x_recip) begin
            x_ff <= rcp_res;
         end else if (cmd.wr_x_sq) begin
            x_ff <= mul_res;
            m_ff <= m_ff >> 1;
         end
      end
   end

   assign status.pass       = pass_ff;
   assign status.neg        = neg_ff;
   assign status.m_zero     = (m_ff == '0);
   assign status.m_one      = (m_ff == 32'd1);
   assign status.m_lsb      = m_ff[0];
   assign status.mul_done   = mul_done;
   assign status.recip_done = rcp_done;

   assign power_bits = res_ff;

endmodule

// ===== rtl/core/dip_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_ctrl: sequencer for the square-and-multiply loop
// Range check, optional reciprocal, then one exponent bit per round.
// ----------------------------------------------------------------------------
module dip_ctrl
   import dip_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      busy      = (state_ff != CS_IDLE);
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = CS_CHECK;
            end
         end
         CS_CHECK: begin
            if (!status.pass) begin
               cmd.clr_res = 1'b1;
               state_in    = CS_DONE;
            end else if (status.neg) begin
               cmd.recip_go = 1'b1;
               state_in     = CS_RECIP;
            end else begin
               state_in = CS_LOOP;
            end
         end
         CS_RECIP: begin
            if (status.recip_done) begin
               cmd.wr_x_recip = 1'b1;
               state_in       = CS_LOOP;
            end
         end
         CS_LOOP: begin
            if (status.m_zero) begin
               state_in = CS_DONE;
            end else if (status.m_lsb) begin
               cmd.mul_go = 1'b1;
               state_in   = CS_MUL;
            end else begin
               cmd.mul_go = 1'b1;
               cmd.mul_sq = 1'b1;
               state_in   = CS_SQR;
            end
         end
         CS_MUL: begin
            if (status.mul_done) begin
               cmd.wr_res = 1'b1;
               // drop the last squaring: nothing reads it
               if (status.m_one) begin
                  state_in = CS_DONE;
               end else begin
                  cmd.mul_go = 1'b1;
                  cmd.mul_sq = 1'b1;
                  state_in   = CS_SQR;
               end
            end
         end
         CS_SQR: begin
            if (status.mul_done) begin
               cmd.wr_x_sq = 1'b1;
               state_in    = CS_LOOP;
            end
         end
         CS_DONE: begin
            rsp_valid = 1'b1;
            state_in  = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/double_integer_power_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_integer_power_core: binary64 base raised to a signed integer power
//
//   channel   ports                                   handshake
//   request   req_base_bits, req_exponent             start & !busy
//   response  rsp_power_bits                          rsp_valid, one cycle
//   config    csr_base_limit                          csr_valid & csr_ready
//
// One item at a time. A multiply forms and accumulates four partial
// products, normalizes the product one bit at a time (more shifts for
// denormals), then rounds. Each exponent bit costs one or two multiplies
// on the shared multiplier; a negative exponent adds a reciprocal (one
// quotient bit a cycle). Reset is synchronous; base_limit resets to 100.
// The response strobe cannot be stalled; csr_ready stays high.
// ----------------------------------------------------------------------------
module double_integer_power_core
   import dip_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [FP_W-1:0]         req_base_bits,
   input  logic signed [EXP_W-1:0] req_exponent,
   output logic                    rsp_valid,
   output logic [FP_W-1:0]         rsp_power_bits,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [LIM_W-1:0]        csr_base_limit
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   dip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   dip_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .base_bits  (req_base_bits),
      .exponent   (req_exponent),
      .lim_we     (csr_valid & csr_ready),
      .lim_data   (csr_base_limit),
      .power_bits (rsp_power_bits)
   );

endmodule
